@@ src/kbtk_pkg.sv @@
// Shared types and constants for the bucketed top-k keeper.
// Used by the RAM-facing datapath, the controller and the top level.
package kbtk_pkg;

   localparam int MAX_BUCKETS  = 4096;
   localparam int BKT_W        = $clog2(MAX_BUCKETS);
   localparam int HEAP_DEPTH   = 8;
   localparam int SLOT_W       = $clog2(HEAP_DEPTH);
   localparam int CNT_W        = 4;
   localparam int TMP_DEPTH    = HEAP_DEPTH + 1;
   localparam int MAX_SYM      = 8;
   localparam int KMER_W       = 64;
   localparam int EV_W         = 40;
   localparam int EV_DEPTH     = MAX_BUCKETS * HEAP_DEPTH;
   localparam int PROD_W       = 16;
   localparam int CSR_W        = 64;

   // status codes
   localparam logic [2:0] ST_ADDED    = 3'd0;
   localparam logic [2:0] ST_EVICTED  = 3'd1;
   localparam logic [2:0] ST_REJECTED = 3'd2;
   localparam logic [2:0] ST_BAD      = 3'd3;
   localparam logic [2:0] ST_ENTRY    = 3'd4;
   localparam logic [2:0] ST_EMPTY    = 3'd5;

   typedef enum logic [1:0] {
      CSR_ALPHABET = 2'd0,
      CSR_SIZE     = 2'd1,
      CSR_KLEN     = 2'd2,
      CSR_LIMIT    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic               kind;
      logic [63:0]        kmer_symbols;
      logic [7:0]         strand_code;
      logic signed [15:0] mean_level;
      logic [15:0]        probability;
      logic [11:0]        bucket_select;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [11:0]        bucket_index;
      logic [3:0]         entry_count;
      logic [15:0]        min_probability;
      logic [63:0]        kmer_out;
      logic [7:0]         entry_strand;
      logic signed [15:0] entry_mean;
      logic [15:0]        entry_probability;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  strand;
      logic [15:0] mean;
      logic [15:0] prob;
   } ev_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_ROUTE, S_IDX, S_IDX_CHK, S_CNT_RD, S_CNT_WAIT,
      S_LD_ADDR, S_LD_DATA, S_DECIDE, S_TRIM, S_ESCAN, S_EVICT, S_WR,
      S_FSCAN, S_KINIT, S_KDIV, S_KPUT, S_EMIT
   } fsm_state_type;

   typedef struct packed {
      logic capture;
      logic idx_step;
      logic clr_step;
      logic cnt_wr;
      logic load_n;
      logic ld_cap;
      logic decide;
      logic j_clr;
      logic scan_init;
      logic scan_step;
      logic evict;
      logic ev_wr;
      logic kinit;
      logic kstep;
      logic kput;
      logic emit_next;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_done;
      logic kind_read;
      logic bad;
      logic dig_last;
      logic j_eq_n;
      logic dec_empty;
      logic dec_take;
      logic over_limit;
      logic bit_last;
      logic rsp_last;
   } dp_stat_type;

endpackage

@@ src/kbtk_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module kbtk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/kbtk_datapath.sv @@
// Datapath: config registers, bucket index, working copy of one bucket,
// min scans, k-mer rebuild divider and both RAMs. Depends on kbtk_pkg, kbtk_ram.
module kbtk_datapath
   import kbtk_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  dp_cmd_type       cmd,
   output dp_stat_type      stat,
   input  req_type          req_data,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   // config
   logic [63:0] alph_ff;
   logic [3:0]  size_ff, klen_ff, limit_ff;
   logic [3:0]  size_eff, klen_eff, lim_eff;

   logic [BKT_W-1:0] clr_ff, clr_in;

   req_type          req_ff, req_in;
   logic [BKT_W-1:0] idx_ff, idx_in;
   logic             bad_ff, bad_in;
   logic [3:0]       dig_ff, dig_in;
   logic [3:0]       n_ff, n_in;
   logic [3:0]       j_ff, j_in;
   logic [15:0]      min_ff, min_in;
   logic [3:0]       mslot_ff, mslot_in;
   logic [2:0]       st_ff, st_in;
   ev_type           tmp_ff [TMP_DEPTH];
   ev_type           tmp_in [TMP_DEPTH];
   logic [BKT_W-1:0] sh_ff, sh_in;
   logic [2:0]       rem_ff, rem_in;
   logic [3:0]       bit_ff, bit_in;
   logic [63:0]      kout_ff, kout_in;

   logic [CNT_W-1:0] cnt_rdata;
   logic [EV_W-1:0]  ev_rdata_raw;
   ev_type           ev_rdata;
   ev_type           tmp_j;
   ev_type           new_ev;
   logic [63:0]      kmask;

   assign size_eff = (size_ff == 4'd0) ? 4'd1 : ((size_ff > 4'd8) ? 4'd8 : size_ff);
   assign klen_eff = (klen_ff == 4'd0) ? 4'd1 : ((klen_ff > 4'd8) ? 4'd8 : klen_ff);
   assign lim_eff  = (limit_ff > 4'd8) ? 4'd8 : limit_ff;

   assign ev_rdata = ev_type'(ev_rdata_raw);
   assign tmp_j    = (j_ff < 4'(TMP_DEPTH)) ? tmp_ff[j_ff] : '0;
   assign new_ev   = '{strand: req_ff.strand_code, mean: req_ff.mean_level,
                       prob: req_ff.probability};

   kbtk_ram #(.WIDTH(CNT_W), .DEPTH(MAX_BUCKETS)) u_cnt_ram (
      .clock (clock),
      .we    (cmd.clr_step | cmd.cnt_wr),
      .waddr (cmd.clr_step ? clr_ff : idx_ff),
      .wdata (cmd.clr_step ? '0 : n_ff),
      .raddr (idx_ff),
      .rdata (cnt_rdata)
   );

   kbtk_ram #(.WIDTH(EV_W), .DEPTH(EV_DEPTH)) u_ev_ram (
      .clock (clock),
      .we    (cmd.ev_wr),
      .waddr ({idx_ff, j_ff[SLOT_W-1:0]}),
      .wdata (tmp_j),
      .raddr ({idx_ff, j_ff[SLOT_W-1:0]}),
      .rdata (ev_rdata_raw)
   );

   always_comb begin
      logic [2:0]        sel;
      logic [7:0]        sym;
      logic              found;
      logic [2:0]        pos;
      logic [PROD_W-1:0] prod;
      logic [3:0]        t;
      logic              ge;
      req_in   = req_ff;
      idx_in   = idx_ff;
      bad_in   = bad_ff;
      dig_in   = dig_ff;
      n_in     = n_ff;
      j_in     = j_ff;
      min_in   = min_ff;
      mslot_in = mslot_ff;
      st_in    = st_ff;
      tmp_in   = tmp_ff;
      sh_in    = sh_ff;
      rem_in   = rem_ff;
      bit_in   = bit_ff;
      kout_in  = kout_ff;
      clr_in   = clr_ff;

      // symbol lookup for the current digit, first symbol most significant
      sel   = 3'(klen_eff - 4'd1 - dig_ff);
      sym   = req_ff.kmer_symbols[{sel, 3'b000} +: 8];
      found = 1'b0;
      pos   = '0;
      for (int p = 0; p < MAX_SYM; p++) begin
         if (!found && (4'(p) < size_eff) && (alph_ff[8*p +: 8] == sym)) begin
            found = 1'b1;
            pos   = 3'(p);
         end
      end
      prod = PROD_W'(idx_ff) * PROD_W'(size_eff) + PROD_W'(pos);

      t  = {rem_ff, sh_ff[BKT_W-1]};
      ge = (t >= size_eff);

      if (cmd.clr_step) begin
         clr_in = clr_ff + 1'b1;
      end
      if (cmd.capture) begin
         req_in = req_data;
         idx_in = req_data.kind ? req_data.bucket_select : '0;
         bad_in = 1'b0;
         dig_in = '0;
      end
      if (cmd.idx_step) begin
         if (!bad_ff) begin
            if (!found || (prod[PROD_W-1:BKT_W] != '0)) begin
               bad_in = 1'b1;
            end else begin
               idx_in = prod[BKT_W-1:0];
            end
         end
         dig_in = dig_ff + 1'b1;
      end
      if (cmd.load_n) begin
         n_in     = (cnt_rdata > 4'd8) ? 4'd8 : cnt_rdata;
         j_in     = '0;
         min_in   = '0;
         mslot_in = '0;
      end
      if (cmd.ld_cap) begin
         tmp_in[j_ff[SLOT_W-1:0]] = ev_rdata;
         if ((j_ff == 4'd0) || (ev_rdata.prob < min_ff)) begin
            min_in   = ev_rdata.prob;
            mslot_in = j_ff;
         end
         j_in = j_ff + 1'b1;
      end
      if (cmd.scan_step) begin
         if ((j_ff == 4'd0) || (tmp_j.prob < min_ff)) begin
            min_in   = tmp_j.prob;
            mslot_in = j_ff;
         end
         j_in = j_ff + 1'b1;
      end
      if (cmd.decide) begin
         j_in = '0;
         if (n_ff == 4'd0) begin
            tmp_in[0] = new_ev;
            n_in      = 4'd1;
            st_in     = ST_ADDED;
         end else if ((min_ff < req_ff.probability) || (n_ff < lim_eff)) begin
            tmp_in[n_ff] = new_ev;
            n_in         = n_ff + 1'b1;
            st_in        = ST_ADDED;
         end else begin
            st_in = ST_REJECTED;
         end
      end
      if (cmd.j_clr) begin
         j_in = '0;
      end
      if (cmd.scan_init) begin
         j_in   = '0;
         min_in = '0;
      end
      if (cmd.evict) begin
         for (int k = 0; k < TMP_DEPTH - 1; k++) begin
            if (4'(k) >= mslot_ff) begin
               tmp_in[k] = tmp_ff[k+1];
            end
         end
         n_in  = n_ff - 1'b1;
         st_in = ST_EVICTED;
      end
      if (cmd.ev_wr || cmd.emit_next) begin
         j_in = j_ff + 1'b1;
      end
      // k-mer rebuild: restoring division by the alphabet size, one bit a cycle
      if (cmd.kinit) begin
         sh_in   = idx_ff;
         rem_in  = '0;
         bit_in  = '0;
         dig_in  = '0;
         kout_in = '0;
         j_in    = '0;
      end
      if (cmd.kstep) begin
         rem_in = ge ? 3'(t - size_eff) : t[2:0];
         sh_in  = {sh_ff[BKT_W-2:0], ge};
         bit_in = bit_ff + 1'b1;
      end
      if (cmd.kput) begin
         kout_in[{dig_ff[2:0], 3'b000} +: 8] = alph_ff[{rem_ff, 3'b000} +: 8];
         rem_in = '0;
         bit_in = '0;
         dig_in = dig_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alph_ff  <= '0;
         size_ff  <= 4'd4;
         klen_ff  <= 4'd5;
         limit_ff <= 4'd8;
         clr_ff   <= '0;
      end else begin
         clr_ff <= clr_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_ALPHABET: alph_ff  <= csr_wdata;
               CSR_SIZE:     size_ff  <= csr_wdata[3:0];
               CSR_KLEN:     klen_ff  <= csr_wdata[3:0];
               CSR_LIMIT:    limit_ff <= csr_wdata[3:0];
               default:      alph_ff  <= alph_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      idx_ff   <= idx_in;
      bad_ff   <= bad_in;
      dig_ff   <= dig_in;
      n_ff     <= n_in;
      j_ff     <= j_in;
      min_ff   <= min_in;
      mslot_ff <= mslot_in;
      st_ff    <= st_in;
      tmp_ff   <= tmp_in;
      sh_ff    <= sh_in;
      rem_ff   <= rem_in;
      bit_ff   <= bit_in;
      kout_ff  <= kout_in;
   end

   always_comb begin
      stat.clr_done   = (clr_ff == '1);
      stat.kind_read  = req_ff.kind;
      stat.bad        = bad_ff;
      stat.dig_last   = (dig_ff == klen_eff - 4'd1);
      stat.j_eq_n     = (j_ff == n_ff);
      stat.dec_empty  = (n_ff == 4'd0);
      stat.dec_take   = (min_ff < req_ff.probability) || (n_ff < lim_eff);
      stat.over_limit = (n_ff > lim_eff);
      stat.bit_last   = (bit_ff == 4'(BKT_W - 1));
      stat.rsp_last   = (n_ff == 4'd0) || (j_ff == n_ff - 4'd1);
   end

   always_comb begin
      for (int b = 0; b < MAX_SYM; b++) begin
         kmask[8*b +: 8] = (4'(b) < klen_eff) ? req_ff.kmer_symbols[8*b +: 8] : 8'd0;
      end
   end

   always_comb begin
      rsp_data = '0;
      if (req_ff.kind) begin
         rsp_data.status          = (n_ff == 4'd0) ? ST_EMPTY : ST_ENTRY;
         rsp_data.bucket_index    = idx_ff;
         rsp_data.entry_count     = n_ff;
         rsp_data.min_probability = min_ff;
         rsp_data.kmer_out        = kout_ff;
         if (n_ff != 4'd0) begin
            rsp_data.entry_strand      = tmp_j.strand;
            rsp_data.entry_mean        = $signed(tmp_j.mean);
            rsp_data.entry_probability = tmp_j.prob;
         end
         rsp_data.last = stat.rsp_last;
      end else begin
         rsp_data.entry_strand      = req_ff.strand_code;
         rsp_data.entry_mean        = req_ff.mean_level;
         rsp_data.entry_probability = req_ff.probability;
         rsp_data.last              = 1'b1;
         if (bad_ff) begin
            rsp_data.status = ST_BAD;
         end else begin
            rsp_data.status          = st_ff;
            rsp_data.bucket_index    = idx_ff;
            rsp_data.entry_count     = n_ff;
            rsp_data.min_probability = min_ff;
            rsp_data.kmer_out        = kmask;
         end
      end
   end

endmodule

@@ src/kbtk_ctrl.sv @@
// Controller state machine: sequences clearing, index build, bucket load,
// insert/evict, write-back, k-mer rebuild and result transactions. Uses kbtk_pkg.
module kbtk_ctrl
   import kbtk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   fsm_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:    if (stat.clr_done) state_in = S_IDLE;
         S_IDLE:     if (req_valid) state_in = S_ROUTE;
         S_ROUTE:    state_in = stat.kind_read ? S_CNT_RD : S_IDX;
         S_IDX:      if (stat.dig_last) state_in = S_IDX_CHK;
         S_IDX_CHK:  state_in = stat.bad ? S_EMIT : S_CNT_RD;
         S_CNT_RD:   state_in = S_CNT_WAIT;
         S_CNT_WAIT: state_in = S_LD_ADDR;
         S_LD_ADDR: begin
            if (stat.j_eq_n) state_in = stat.kind_read ? S_KINIT : S_DECIDE;
            else state_in = S_LD_DATA;
         end
         S_LD_DATA:  state_in = S_LD_ADDR;
         S_DECIDE: begin
            if (stat.dec_empty) state_in = S_WR;
            else if (stat.dec_take) state_in = S_TRIM;
            else state_in = S_EMIT;
         end
         S_TRIM:     state_in = stat.over_limit ? S_ESCAN : S_WR;
         S_ESCAN:    if (stat.j_eq_n) state_in = S_EVICT;
         S_EVICT:    state_in = S_TRIM;
         S_WR:       if (stat.j_eq_n) state_in = S_FSCAN;
         S_FSCAN:    if (stat.j_eq_n) state_in = S_EMIT;
         S_KINIT:    state_in = S_KDIV;
         S_KDIV:     if (stat.bit_last) state_in = S_KPUT;
         S_KPUT:     state_in = stat.dig_last ? S_EMIT : S_KDIV;
         S_EMIT: begin
            if (!rsp_stall && (!stat.kind_read || stat.rsp_last)) state_in = S_IDLE;
         end
         default:    state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_CLEAR:    cmd.clr_step = 1'b1;
         S_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         S_ROUTE:    cmd.capture = 1'b0;
         S_IDX:      cmd.idx_step = 1'b1;
         S_IDX_CHK:  cmd.idx_step = 1'b0;
         S_CNT_RD:   cmd.load_n = 1'b0;
         S_CNT_WAIT: cmd.load_n = 1'b1;
         S_LD_ADDR:  cmd.ld_cap = 1'b0;
         S_LD_DATA:  cmd.ld_cap = 1'b1;
         S_DECIDE:   cmd.decide = 1'b1;
         S_TRIM:     cmd.j_clr = 1'b1;
         S_ESCAN:    cmd.scan_step = !stat.j_eq_n;
         S_EVICT:    cmd.evict = 1'b1;
         S_WR: begin
            cmd.ev_wr     = !stat.j_eq_n;
            cmd.cnt_wr    = stat.j_eq_n;
            cmd.scan_init = stat.j_eq_n;
         end
         S_FSCAN:    cmd.scan_step = !stat.j_eq_n;
         S_KINIT:    cmd.kinit = 1'b1;
         S_KDIV:     cmd.kstep = 1'b1;
         S_KPUT:     cmd.kput = 1'b1;
         S_EMIT: begin
            rsp_valid     = 1'b1;
            cmd.emit_next = !rsp_stall && stat.kind_read && !stat.rsp_last;
         end
         default:    cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/kmer_bucketed_top_k_keeper.sv @@
// Top level of the bucketed top-k keeper.
// Depends on kbtk_pkg, kbtk_ctrl, kbtk_datapath (which holds kbtk_ram instances).

// Keeps, per k-mer bucket, up to eight events with the highest probability; a
// taken insert into a non-empty bucket then trims the bucket to heap_limit.
// An insert transaction maps its k-mer to a bucket (one symbol a cycle); unless
// the k-mer is bad it loads the bucket's count and entries from RAM and, if the
// event is taken, adds it, evicts minima while over the limit and writes the
// bucket back. It returns one result. A read transaction loads the bucket,
// rebuilds the k-mer text with a bit-serial divider and returns one result per
// held entry, or one "bucket empty" result. One transaction is worked on at a
// time; the next is taken only once the block is back in idle, and result
// stalls hold it in its result state. After reset a clearing pass zeroes the
// count RAM; req_stall stays high during it, while configuration writes are
// taken as ever. The user must write configuration only while the block is
// idle; the block itself does not enforce this.
module kmer_bucketed_top_k_keeper
   import kbtk_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   kbtk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   kbtk_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

@@ tb/kmer_bucketed_top_k_keeper_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for kmer_bucketed_top_k_keeper.
// Needs kbtk_pkg and the keeper RTL; a local predictor models the bucket store.

module kmer_bucketed_top_k_keeper_tb;
   import kbtk_pkg::*;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_stall;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1;
   rsp_type          rsp_data;
   logic             csr_we = 0;
   logic [1:0]       csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   kmer_bucketed_top_k_keeper u_top (.*);

   always #10 clock = ~clock;

   // predictor copy of the registers and of the bucket store
   logic [63:0] alpha_bytes;
   logic [3:0]  alpha_size_reg, klen_reg, heap_limit_reg;
   ev_type      bucket_ev[MAX_BUCKETS][HEAP_DEPTH];
   int          bucket_n[MAX_BUCKETS];

   rsp_type     expected_rsp[$];
   int          errors = 0;
   bit          idle_on = 1;
   int          rx_hold = 0;      // long receiver hold-off, consumed by the receiver
   int          rx_gap = 0;       // per-transaction stall drawn on acceptance
   int          quiet_cycles = 0;

   function automatic int eff_size();
      return alpha_size_reg < 1 ? 1 : (alpha_size_reg > 8 ? 8 : alpha_size_reg);
   endfunction

   function automatic int eff_len();
      return klen_reg < 1 ? 1 : (klen_reg > MAX_SYM ? MAX_SYM : klen_reg);
   endfunction

   function automatic int eff_limit();
      return heap_limit_reg > HEAP_DEPTH ? HEAP_DEPTH : heap_limit_reg;
   endfunction

   // first slot holding the lowest probability
   function automatic int lowest_slot(ev_type a[HEAP_DEPTH+1], int n);
      int m;
      m = 0;
      for (int i = 1; i < n; i++)
         if (a[i].prob < a[m].prob) m = i;
      return m;
   endfunction

   function automatic logic [63:0] kmer_of_bucket(longint idx);
      logic [63:0] km;
      longint r;
      int d;
      km = '0;
      r = idx;
      for (int i = 0; i < eff_len(); i++) begin
         d = r % eff_size();
         km[8*i +: 8] = alpha_bytes[8*d +: 8];
         r = r / eff_size();
      end
      return km;
   endfunction

   function automatic void load_bucket(int b, output ev_type a[HEAP_DEPTH+1]);
      for (int k = 0; k < HEAP_DEPTH; k++) a[k] = bucket_ev[b][k];
      a[HEAP_DEPTH] = '0;
   endfunction

   function automatic void predict_insert(req_type r);
      ev_type  e, hp[HEAP_DEPTH+1];
      longint  idx;
      int      n, pos, m, lim;
      bit      bad;
      logic [7:0] sym;
      rsp_type x;
      e.strand = r.strand_code;
      e.mean   = r.mean_level;
      e.prob   = r.probability;
      lim = eff_limit();
      idx = 0;
      bad = 0;
      for (int i = 0; i < eff_len() && !bad; i++) begin
         sym = r.kmer_symbols[8*(eff_len()-1-i) +: 8];
         pos = eff_size();
         for (int p = eff_size() - 1; p >= 0; p--)
            if (alpha_bytes[8*p +: 8] == sym) pos = p;
         if (pos == eff_size()) bad = 1;
         else idx = idx * eff_size() + pos;
      end
      x = '0;
      x.entry_strand      = e.strand;
      x.entry_mean        = e.mean;
      x.entry_probability = e.prob;
      x.last              = 1'b1;
      if (bad || idx >= MAX_BUCKETS) begin
         x.status = ST_BAD;
         expected_rsp = {expected_rsp, x};
         return;
      end
      n = bucket_n[idx];
      load_bucket(int'(idx), hp);
      if (n == 0) begin
         bucket_ev[idx][0] = e;
         n = 1;
         x.status = ST_ADDED;
      end else if (hp[lowest_slot(hp, n)].prob < e.prob || n < lim) begin
         hp[n] = e;
         n++;
         x.status = ST_ADDED;
         while (n > lim) begin
            m = lowest_slot(hp, n);
            for (int k = m; k + 1 < n; k++) hp[k] = hp[k+1];
            n--;
            x.status = ST_EVICTED;
         end
         for (int k = 0; k < n; k++) bucket_ev[idx][k] = hp[k];
      end else begin
         x.status = ST_REJECTED;
      end
      bucket_n[idx] = n;
      load_bucket(int'(idx), hp);
      x.bucket_index    = 12'(idx);
      x.entry_count     = 4'(n);
      x.min_probability = n ? hp[lowest_slot(hp, n)].prob : 16'd0;
      x.kmer_out        = kmer_of_bucket(idx);
      expected_rsp = {expected_rsp, x};
   endfunction

   function automatic void predict_read(req_type r);
      ev_type  hp[HEAP_DEPTH+1];
      int      b, n;
      rsp_type x;
      b = int'(r.bucket_select);
      n = bucket_n[b];
      load_bucket(b, hp);
      x = '0;
      x.bucket_index = 12'(b);
      x.kmer_out     = kmer_of_bucket(b);
      if (n == 0) begin
         x.status = ST_EMPTY;
         x.last   = 1'b1;
         expected_rsp = {expected_rsp, x};
         return;
      end
      x.status          = ST_ENTRY;
      x.entry_count     = 4'(n);
      x.min_probability = hp[lowest_slot(hp, n)].prob;
      for (int k = 0; k < n; k++) begin
         x.entry_strand      = hp[k].strand;
         x.entry_mean        = hp[k].mean;
         x.entry_probability = hp[k].prob;
         x.last              = (k + 1 == n);
         expected_rsp = {expected_rsp, x};
      end
   endfunction

   // ---------------------------------------------------------------- driving
   // Called at a falling edge; returns at the falling edge after acceptance.
   // Valid is only lowered when a gap follows, so it never toggles in one step.
   task automatic send_req(input req_type r, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (r.kind) predict_read(r);
      else predict_insert(r);
      @(negedge clock);
   endtask

   function automatic int draw_gap();
      return idle_on ? $urandom_range(0, 9) : 0;
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);   // let the block return to idle
   endtask

   // all four registers, back to back; only while the block is idle
   task automatic write_regs(input logic [63:0] alpha, input logic [3:0] sz,
                             input logic [3:0] kl, input logic [3:0] lim);
      csr_index_type ix[4];
      logic [63:0]   val[4];
      wait_drained();
      ix  = '{CSR_ALPHABET, CSR_SIZE, CSR_KLEN, CSR_LIMIT};
      val = '{alpha, {60'd0, sz}, {60'd0, kl}, {60'd0, lim}};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= ix[i];
         csr_wdata <= val[i];
         @(negedge clock);
      end
      csr_we <= 1'b0;
      alpha_bytes    = alpha;
      alpha_size_reg = sz;
      klen_reg       = kl;
      heap_limit_reg = lim;
   endtask

   // k-mer from alphabet positions; unused high bytes carry noise
   function automatic logic [63:0] kmer_from(int pos[8]);
      logic [63:0] km;
      km = {$urandom, $urandom};
      for (int i = 0; i < eff_len(); i++)
         km[8*(eff_len()-1-i) +: 8] = alpha_bytes[8*pos[i] +: 8];
      return km;
   endfunction

   function automatic req_type rand_insert(int bad_pct);
      req_type r;
      int pos[8];
      for (int i = 0; i < 8; i++) pos[i] = $urandom_range(0, eff_size() - 1);
      r.kind          = 1'b0;
      r.kmer_symbols  = kmer_from(pos);
      if ($urandom_range(0, 99) < bad_pct)
         r.kmer_symbols[8*$urandom_range(0, eff_len()-1) +: 8] = $urandom;
      r.strand_code   = $urandom;
      r.mean_level    = $urandom;
      r.probability   = $urandom;
      r.bucket_select = $urandom;
      return r;
   endfunction

   function automatic req_type read_of(int b);
      req_type r;
      r = rand_insert(0);
      r.kind = 1'b1;
      r.bucket_select = b;
      return r;
   endfunction

   function automatic req_type insert_of(int pos0, logic [15:0] prob);
      req_type r;
      int pos[8];
      r = rand_insert(0);
      pos = '{default: 0};
      pos[0] = pos0;
      r.kmer_symbols = kmer_from(pos);
      r.probability  = prob;
      return r;
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic check_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      rsp_type x;
      if (!reset && rsp_valid && !rsp_stall) begin
         rx_gap = draw_gap();
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, got %h", $time, rsp_data);
         end else begin
            x = expected_rsp.pop_front();
            check_field("status",            x.status,            rsp_data.status);
            check_field("bucket_index",      x.bucket_index,      rsp_data.bucket_index);
            check_field("entry_count",       x.entry_count,       rsp_data.entry_count);
            check_field("min_probability",   x.min_probability,   rsp_data.min_probability);
            check_field("kmer_out",          x.kmer_out,          rsp_data.kmer_out);
            check_field("entry_strand",      x.entry_strand,      rsp_data.entry_strand);
            check_field("entry_mean",        x.entry_mean,        rsp_data.entry_mean);
            check_field("entry_probability", x.entry_probability, rsp_data.entry_probability);
            check_field("last",              x.last,              rsp_data.last);
         end
      end
   end

   // receiver: long hold-off first, then the per-transaction stall
   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rsp_stall <= 1'b1;
         rx_hold = rx_hold - 1;
      end else if (rx_gap > 0) begin
         rsp_stall <= 1'b1;
         rx_gap = rx_gap - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog: covers the clearing pass, the hold-off and the slowest transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= 20000) begin
         $display("kmer_bucketed_top_k_keeper regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests
   // Power-up registers: alphabet all zero bytes, so a zero k-mer is bucket 0.
   task automatic test_field_extremes();
      req_type r;
      r = '0;
      send_req(r, 0);                       // empty bucket, zero probability
      r.strand_code = 8'hFF; r.mean_level = 16'sh7FFF; r.probability = 16'hFFFF;
      send_req(r, 1);
      r.strand_code = 8'h00; r.mean_level = -16'sd32768; r.probability = 16'h8000;
      send_req(r, 0);
      r.kmer_symbols = 64'h0000_0001_0000_0000;   // unknown symbol, first byte
      send_req(r, 2);
      r.kmer_symbols = 64'hFFFF_FF00_0000_0000;   // bytes above the k-mer length ignored
      send_req(r, 0);
      send_req(read_of(0), 0);
      send_req(read_of(4095), 3);           // empty bucket
   endtask

   // equal minima: oldest slot evicted first; a take needs strictly greater
   task automatic test_equal_minima();
      write_regs(64'h0000_0000_5447_4341, 4'd4, 4'd2, 4'd2);
      send_req(insert_of(1, 16'd500), 0);
      send_req(insert_of(1, 16'd500), 0);
      send_req(insert_of(1, 16'd500), 0);   // equal to minimum: rejected
      send_req(insert_of(1, 16'd501), 0);   // evicts slot 0
      send_req(read_of(4), 0);
   endtask

   // heap limit zero: empty bucket takes one, the next taken one empties it
   task automatic test_limit_zero();
      write_regs(64'h0000_0000_5447_4341, 4'd4, 4'd2, 4'd0);
      send_req(insert_of(2, 16'd10), 0);
      send_req(insert_of(2, 16'd5), 0);
      send_req(insert_of(2, 16'd20), 0);
      send_req(read_of(8), 0);
      send_req(insert_of(2, 16'd1), 0);
   endtask

   // limit lowered under the held count: rejection keeps all, a take trims
   task automatic test_limit_lowered();
      write_regs(64'h0000_0000_5447_4341, 4'd4, 4'd2, 4'd8);
      for (int i = 0; i < 6; i++) send_req(insert_of(3, 16'd100 + 16'(i)), 0);
      write_regs(64'h0000_0000_5447_4341, 4'd4, 4'd2, 4'd2);
      send_req(insert_of(3, 16'd50), 0);
      send_req(read_of(12), 0);
      send_req(insert_of(3, 16'd900), 0);
      send_req(read_of(12), 0);
   endtask

   // receiver holds off while the sender keeps offering back to back
   task automatic test_backpressure();
      rx_hold = 300;
      for (int i = 0; i < 16; i++)
         send_req(i % 4 == 3 ? read_of($urandom_range(0, 15)) : rand_insert(5), 0);
   endtask

   // sender pauses until every result is back
   task automatic test_drain_pause();
      for (int i = 0; i < 8; i++) send_req(rand_insert(5), draw_gap());
      wait_drained();
      send_req(read_of($urandom_range(0, 15)), 0);
   endtask

   task automatic run_random_phase(input logic [63:0] alpha, input logic [3:0] sz,
                                   input logic [3:0] kl, input logic [3:0] lim,
                                   input int items, input int read_top);
      write_regs(alpha, sz, kl, lim);
      for (int i = 0; i < items; i++) begin
         if (i % 40 == 0) idle_on = $urandom_range(0, 2) != 0;
         if ($urandom_range(0, 99) < 25)
            send_req(read_of($urandom_range(0, 9) == 0 ? $urandom_range(0, 4095)
                                                       : $urandom_range(0, read_top)),
                     draw_gap());
         else
            send_req(rand_insert(6), draw_gap());
      end
      idle_on = 1;
   endtask

   task automatic test_random();
      run_random_phase(64'h0000_0000_5447_4341, 4'd4,  4'd3,  4'd8,  50,  63);
      run_random_phase(64'h0000_0000_5447_4341, 4'd4,  4'd2,  4'd3,  80,  15);
      run_random_phase(64'h0000_0000_0000_4341, 4'd2,  4'd3,  4'd1,  60,  7);
      run_random_phase(64'h8070_6050_4030_2010, 4'd8,  4'd4,  4'd8,  50,  4095);
      run_random_phase(64'h8070_6050_4030_2010, 4'd8,  4'd5,  4'd4,  30,  4095);
      run_random_phase(64'hFFFF_FFFF_FFFF_FFFF, 4'd0,  4'd15, 4'd15, 60,  3);
      run_random_phase(64'hF7E6_D5C4_B3A2_9180, 4'd15, 4'd0,  4'd2,  50,  15);
      run_random_phase(64'h0000_0000_0033_2211, 4'd3,  4'd1,  4'd0,  50,  5);
   endtask

   initial begin
      alpha_bytes    = '0;
      alpha_size_reg = 4'd4;
      klen_reg       = 4'd5;
      heap_limit_reg = 4'd8;
      for (int b = 0; b < MAX_BUCKETS; b++) bucket_n[b] = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_equal_minima();
      test_limit_zero();
      test_limit_lowered();
      test_backpressure();
      test_drain_pause();
      test_random();

      wait_drained();
      repeat (200) @(negedge clock);
      if (errors == 0)
         $display("kmer_bucketed_top_k_keeper regression: pass");
      else
         $display("kmer_bucketed_top_k_keeper regression: fail");
      $finish;
   end

endmodule
